FILE: hw/rtl/sdpe_pkg.sv
// ---------------------------------------------------------------------------
// Strided dot-product engine package
// Request layouts, register indexes and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package sdpe_pkg;

    localparam int ADDR_FIELD_W  = 32;
    localparam int COUNT_FIELD_W = 32;
    localparam int DATA_FIELD_W  = 64;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_INDEX_W   = 2;

    localparam int IN_BASE_A_LSB = 0;
    localparam int IN_BASE_B_LSB = IN_BASE_A_LSB + ADDR_FIELD_W;
    localparam int IN_COUNT_LSB  = IN_BASE_B_LSB + ADDR_FIELD_W;
    localparam int IN_IACC_LSB   = IN_COUNT_LSB + COUNT_FIELD_W;
    localparam int IN_IWA_LSB    = IN_IACC_LSB + DATA_FIELD_W;
    localparam int IN_IWB_LSB    = IN_IWA_LSB + DATA_FIELD_W;
    localparam int IN_MWA_LSB    = IN_IWB_LSB + DATA_FIELD_W;
    localparam int IN_MWB_LSB    = IN_MWA_LSB + DATA_FIELD_W;
    localparam int IN_FIELDS_W   = IN_MWB_LSB + DATA_FIELD_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int OUT_ADDR_A_LSB = 0;
    localparam int OUT_ADDR_B_LSB = OUT_ADDR_A_LSB + ADDR_FIELD_W;
    localparam int OUT_ACC_LSB    = OUT_ADDR_B_LSB + ADDR_FIELD_W;
    localparam int OUT_STEPS_LSB  = OUT_ACC_LSB + DATA_FIELD_W;
    localparam int OUT_BUSY_BIT   = OUT_STEPS_LSB + COUNT_FIELD_W;
    localparam int OUT_DONE_BIT   = OUT_BUSY_BIT + 1;
    localparam int OUT_FIELDS_W   = OUT_DONE_BIT + 1;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W      = OUT_TDATA_W - OUT_FIELDS_W;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_TICK  = 1'b1
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STRIDE_A = 2'd0,
        REG_STRIDE_B = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } stage_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sdpe_operand_stage.sv
// ---------------------------------------------------------------------------
// Operand stage
// Input register for requests. The data words that a request would load as
// the new held pair are split into halves and multiplied here, so that the
// product of the held pair is ready for the following tick.
// ---------------------------------------------------------------------------
`default_nettype none

module sdpe_operand_stage #(
    parameter int ADDR_WIDTH  = 32,
    parameter int DATA_WIDTH  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [sdpe_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                             s_tuser,
    input  wire logic                             take,
    output      sdpe_pkg::stage_ctl_t             ctl,
    output      logic [ADDR_WIDTH-1:0]            base_a,
    output      logic [ADDR_WIDTH-1:0]            base_b,
    output      logic [COUNT_WIDTH-1:0]           step_count,
    output      logic [DATA_WIDTH-1:0]            initial_acc,
    output      logic [DATA_WIDTH-1:0]            prod_low,
    output      logic [DATA_WIDTH-(DATA_WIDTH+1)/2-1:0] prod_cross
);
    import sdpe_pkg::*;

    localparam int HALF_W = (DATA_WIDTH + 1) / 2;
    localparam int HI_W   = DATA_WIDTH - HALF_W;

    stage_ctl_t             ctl_reg;
    logic [ADDR_WIDTH-1:0]  base_a_reg;
    logic [ADDR_WIDTH-1:0]  base_b_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [DATA_WIDTH-1:0]  iacc_reg;
    logic [DATA_WIDTH-1:0]  prod_low_reg;
    logic [HI_W-1:0]        prod_cross_reg;

    kind_t                  kind_in;
    logic [DATA_WIDTH-1:0]  word_a;
    logic [DATA_WIDTH-1:0]  word_b;
    logic [HALF_W-1:0]      a_lo;
    logic [HALF_W-1:0]      b_lo;
    logic [HALF_W-1:0]      a_hi;
    logic [HALF_W-1:0]      b_hi;
    logic [2*HALF_W-1:0]    low_full;
    logic [HALF_W-1:0]      cross_full;

    assign kind_in = kind_t'(s_tuser);

    always_comb
    begin
        if (kind_in == KIND_START)
        begin
            word_a = DATA_WIDTH'(s_tdata[IN_IWA_LSB +: DATA_FIELD_W]);
            word_b = DATA_WIDTH'(s_tdata[IN_IWB_LSB +: DATA_FIELD_W]);
        end
        else
        begin
            word_a = DATA_WIDTH'(s_tdata[IN_MWA_LSB +: DATA_FIELD_W]);
            word_b = DATA_WIDTH'(s_tdata[IN_MWB_LSB +: DATA_FIELD_W]);
        end
    end

    assign a_lo = word_a[HALF_W-1:0];
    assign b_lo = word_b[HALF_W-1:0];
    assign a_hi = HALF_W'(word_a[DATA_WIDTH-1:HALF_W]);
    assign b_hi = HALF_W'(word_b[DATA_WIDTH-1:HALF_W]);

    assign low_full   = (2*HALF_W)'(a_lo) * (2*HALF_W)'(b_lo);
    assign cross_full = a_lo * b_hi + a_hi * b_lo;

    assign s_tready = !ctl_reg.valid || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, kind: KIND_START};
        end
        else if (s_tready)
        begin
            ctl_reg <= '{valid: s_tvalid, kind: kind_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            base_a_reg     <= ADDR_WIDTH'(s_tdata[IN_BASE_A_LSB +: ADDR_FIELD_W]);
            base_b_reg     <= ADDR_WIDTH'(s_tdata[IN_BASE_B_LSB +: ADDR_FIELD_W]);
            count_reg      <= COUNT_WIDTH'(s_tdata[IN_COUNT_LSB +: COUNT_FIELD_W]);
            iacc_reg       <= DATA_WIDTH'(s_tdata[IN_IACC_LSB +: DATA_FIELD_W]);
            prod_low_reg   <= low_full[DATA_WIDTH-1:0];
            prod_cross_reg <= cross_full[HI_W-1:0];
        end
    end

    assign ctl         = ctl_reg;
    assign base_a      = base_a_reg;
    assign base_b      = base_b_reg;
    assign step_count  = count_reg;
    assign initial_acc = iacc_reg;
    assign prod_low    = prod_low_reg;
    assign prod_cross  = prod_cross_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sdpe_core.sv
// ---------------------------------------------------------------------------
// Engine core
// Stride registers, engine state and result valid. The state registers are
// updated once per request and also serve as the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module sdpe_core #(
    parameter int ADDR_WIDTH  = 32,
    parameter int DATA_WIDTH  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [sdpe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ADDR_WIDTH-1:0]              cfg_data,
    input  wire sdpe_pkg::stage_ctl_t               ctl,
    input  wire logic [ADDR_WIDTH-1:0]              base_a,
    input  wire logic [ADDR_WIDTH-1:0]              base_b,
    input  wire logic [COUNT_WIDTH-1:0]             step_count,
    input  wire logic [DATA_WIDTH-1:0]              initial_acc,
    input  wire logic [DATA_WIDTH-1:0]              prod_low,
    input  wire logic [DATA_WIDTH-(DATA_WIDTH+1)/2-1:0] prod_cross,
    output      logic                               take,
    input  wire logic                               m_tready,
    output      logic                               m_tvalid,
    output      logic [ADDR_WIDTH-1:0]              addr_a,
    output      logic [ADDR_WIDTH-1:0]              addr_b,
    output      logic [DATA_WIDTH-1:0]              acc,
    output      logic [COUNT_WIDTH-1:0]             remaining,
    output      logic                               running,
    output      logic                               finished
);
    import sdpe_pkg::*;

    localparam int HALF_W = (DATA_WIDTH + 1) / 2;

    logic [ADDR_WIDTH-1:0]  stride_a_reg;
    logic [ADDR_WIDTH-1:0]  stride_b_reg;
    logic [ADDR_WIDTH-1:0]  addr_a_reg,    addr_a_next;
    logic [ADDR_WIDTH-1:0]  addr_b_reg,    addr_b_next;
    logic [DATA_WIDTH-1:0]  acc_reg,       acc_next;
    logic [DATA_WIDTH-1:0]  held_prod_reg, held_prod_next;
    logic [COUNT_WIDTH-1:0] remaining_reg, remaining_next;
    logic                   running_reg,   running_next;
    logic                   finished_reg,  finished_next;
    logic                   out_valid_reg, out_valid_next;

    logic [DATA_WIDTH-1:0]  new_prod;
    logic [COUNT_WIDTH-1:0] remaining_dec;
    logic                   fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_a_reg <= '0;
            stride_b_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STRIDE_A: stride_a_reg <= cfg_data;
                REG_STRIDE_B: stride_b_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // The product of the pair that the request loads is rebuilt from its registered partial products.
    assign new_prod      = prod_low + (DATA_WIDTH'(prod_cross) << HALF_W);
    assign remaining_dec = remaining_reg - COUNT_WIDTH'(1);

    assign take = !out_valid_reg || m_tready;
    assign fire = ctl.valid && take;

    always_comb
    begin
        addr_a_next    = addr_a_reg;
        addr_b_next    = addr_b_reg;
        acc_next       = acc_reg;
        held_prod_next = held_prod_reg;
        remaining_next = remaining_reg;
        running_next   = running_reg;
        finished_next  = finished_reg;
        out_valid_next = take ? ctl.valid : out_valid_reg;
        if (fire)
        begin
            if (ctl.kind == KIND_START)
            begin
                addr_a_next    = base_a;
                addr_b_next    = base_b;
                acc_next       = initial_acc;
                held_prod_next = new_prod;
                remaining_next = step_count;
                running_next   = (step_count != '0);
                finished_next  = (step_count == '0);
            end
            else if (running_reg)
            begin
                acc_next       = acc_reg + held_prod_reg;
                held_prod_next = new_prod;
                addr_a_next    = addr_a_reg + stride_a_reg;
                addr_b_next    = addr_b_reg + stride_b_reg;
                remaining_next = remaining_dec;
                if (remaining_dec == '0)
                begin
                    running_next  = 1'b0;
                    finished_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_a_reg    <= '0;
            addr_b_reg    <= '0;
            acc_reg       <= '0;
            held_prod_reg <= '0;
            remaining_reg <= '0;
            running_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            addr_a_reg    <= addr_a_next;
            addr_b_reg    <= addr_b_next;
            acc_reg       <= acc_next;
            held_prod_reg <= held_prod_next;
            remaining_reg <= remaining_next;
            running_reg   <= running_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign addr_a    = addr_a_reg;
    assign addr_b    = addr_b_reg;
    assign acc       = acc_reg;
    assign remaining = remaining_reg;
    assign running   = running_reg;
    assign finished  = finished_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/strided_dot_product_engine_top.sv
// ---------------------------------------------------------------------------
// Strided dot-product engine
// Multiply-accumulate engine that walks two strided operand streams.
// ---------------------------------------------------------------------------
// A start request (s_tuser low) loads the base addresses, the step count, the
// starting accumulator and the first held operand pair. Each tick request
// (s_tuser high) while busy adds the product of the held pair to the
// accumulator, takes the memory words it carries as the new held pair, moves
// both addresses on by their strides and counts down. Every request yields
// exactly one result request with the state after it: the addresses the next
// tick must carry, the accumulator, the steps left and busy and done flags.
// The strides must be written through the cfg port only while the engine is
// idle; the block itself does not enforce it. A request is accepted into the
// operand register, which holds the partial products of the next held pair,
// and reaches m_tdata through the state register, which doubles as the result.
// One request is taken in every cycle while the receiver is ready.
// When the receiver stalls, the result holds, and the input side takes a
// request into its operand register only while that register is empty.
// Reset clears the state, both strides and both valid flags.
// ---------------------------------------------------------------------------
`default_nettype none

module strided_dot_product_engine_top #(
    parameter int ADDR_WIDTH  = 32,
    parameter int DATA_WIDTH  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [sdpe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ADDR_WIDTH-1:0]             cfg_data,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // base_a, base_b, step_count, initial_acc, initial_word_a,
    // initial_word_b, mem_word_a, mem_word_b
    input  wire logic [sdpe_pkg::IN_TDATA_W-1:0]   s_tdata,
    // kind
    input  wire logic                              s_tuser,
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // read_addr_a, read_addr_b, accumulator, steps_left, busy_res, done_res,
    // zero padding
    output      logic [sdpe_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import sdpe_pkg::*;

    localparam int HI_W = DATA_WIDTH - (DATA_WIDTH + 1) / 2;

    stage_ctl_t             ctl;
    logic                   take;
    logic [ADDR_WIDTH-1:0]  base_a;
    logic [ADDR_WIDTH-1:0]  base_b;
    logic [COUNT_WIDTH-1:0] step_count;
    logic [DATA_WIDTH-1:0]  initial_acc;
    logic [DATA_WIDTH-1:0]  prod_low;
    logic [HI_W-1:0]        prod_cross;
    logic [ADDR_WIDTH-1:0]  addr_a;
    logic [ADDR_WIDTH-1:0]  addr_b;
    logic [DATA_WIDTH-1:0]  acc;
    logic [COUNT_WIDTH-1:0] remaining;
    logic                   running;
    logic                   finished;

    sdpe_operand_stage #(
        .ADDR_WIDTH  (ADDR_WIDTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_operand_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .take        (take),
        .ctl         (ctl),
        .base_a      (base_a),
        .base_b      (base_b),
        .step_count  (step_count),
        .initial_acc (initial_acc),
        .prod_low    (prod_low),
        .prod_cross  (prod_cross)
    );

    sdpe_core #(
        .ADDR_WIDTH  (ADDR_WIDTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ctl         (ctl),
        .base_a      (base_a),
        .base_b      (base_b),
        .step_count  (step_count),
        .initial_acc (initial_acc),
        .prod_low    (prod_low),
        .prod_cross  (prod_cross),
        .take        (take),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .addr_a      (addr_a),
        .addr_b      (addr_b),
        .acc         (acc),
        .remaining   (remaining),
        .running     (running),
        .finished    (finished)
    );

    assign m_tdata = {
        {OUT_PAD_W{1'b0}},
        finished,
        running,
        COUNT_FIELD_W'(remaining),
        DATA_FIELD_W'(acc),
        ADDR_FIELD_W'(addr_b),
        ADDR_FIELD_W'(addr_a)
    };

endmodule

`default_nettype wire

FILE: hw/rtl/sdpe_checker.sv
// ---------------------------------------------------------------------------
// Engine port checker
// Checks the result stream of the engine as seen on its ports.
// ---------------------------------------------------------------------------
`default_nettype none

module sdpe_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [sdpe_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import sdpe_pkg::*;

    logic                     busy;
    logic                     done;
    logic [COUNT_FIELD_W-1:0] steps;

    assign busy  = m_tdata[OUT_BUSY_BIT];
    assign done  = m_tdata[OUT_DONE_BIT];
    assign steps = m_tdata[OUT_STEPS_LSB +: COUNT_FIELD_W];

    a_no_result_in_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_busy_done_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(busy && done))
        else $error("busy and done both set");

    a_busy_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && busy |-> steps != '0)
        else $error("busy with no steps left");

    a_done_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && done |-> steps == '0)
        else $error("done with steps left");

endmodule

bind strided_dot_product_engine_top sdpe_checker u_sdpe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: sim/strided_dot_product_engine_top_test.sv
// ---------------------------------------------------------------------------
// Strided dot-product engine testbench
// Sends start and tick requests in bursts with random gaps while the result
// side stalls on its own pattern, predicts every result from a local model
// of the engine state and checks the result stream in order, field by field.
// ---------------------------------------------------------------------------
module strided_dot_product_engine_top_test;

    import sdpe_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1880;
    localparam int RANDOM_PHASES  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] base_a;
        logic [31:0] base_b;
        logic [31:0] step_count;
        logic [63:0] initial_acc;
        logic [63:0] initial_word_a;
        logic [63:0] initial_word_b;
        logic [63:0] mem_word_a;
        logic [63:0] mem_word_b;
    } mac_request_t;

    typedef struct packed {
        logic [31:0] read_addr_a;
        logic [31:0] read_addr_b;
        logic [63:0] accumulator;
        logic [31:0] steps_left;
        logic        busy;
        logic        done;
    } engine_snapshot_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b1;
    logic                    cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    logic [31:0] stride_a_q = '0;
    logic [31:0] stride_b_q = '0;
    logic [31:0] eng_addr_a = '0;
    logic [31:0] eng_addr_b = '0;
    logic [63:0] eng_held_a = '0;
    logic [63:0] eng_held_b = '0;
    logic [63:0] eng_acc = '0;
    logic [31:0] eng_remaining = '0;
    logic        eng_running = 1'b0;
    logic        eng_finished = 1'b0;

    engine_snapshot_t expected_snapshots[$];
    int               mismatch_count = 0;
    int               burst_left = 0;
    int               stalled_cycles = 0;
    int               rx_mode = 0;
    int               rx_mode_left = 0;
    int               rx_phase = 0;
    int               rx_period = 2;

    strided_dot_product_engine_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic engine_snapshot_t advance_engine(input mac_request_t req);
        engine_snapshot_t snap;
        if (req.kind == KIND_START)
        begin
            eng_addr_a    = req.base_a;
            eng_addr_b    = req.base_b;
            eng_remaining = req.step_count;
            eng_acc       = req.initial_acc;
            eng_held_a    = req.initial_word_a;
            eng_held_b    = req.initial_word_b;
            eng_running   = (req.step_count != 0);
            eng_finished  = (req.step_count == 0);
        end
        else if (eng_running)
        begin
            eng_acc       = eng_acc + eng_held_a * eng_held_b;
            eng_held_a    = req.mem_word_a;
            eng_held_b    = req.mem_word_b;
            eng_addr_a    = eng_addr_a + stride_a_q;
            eng_addr_b    = eng_addr_b + stride_b_q;
            eng_remaining = eng_remaining - 32'd1;
            if (eng_remaining == 0)
            begin
                eng_running  = 1'b0;
                eng_finished = 1'b1;
            end
        end
        snap.read_addr_a = eng_addr_a;
        snap.read_addr_b = eng_addr_b;
        snap.accumulator = eng_acc;
        snap.steps_left  = eng_remaining;
        snap.busy        = eng_running;
        snap.done        = eng_finished;
        return snap;
    endfunction

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return {32'd0, $urandom_range(0, 15)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] rand32();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic mac_request_t make_start(input logic [31:0] base_a,
                                                input logic [31:0] base_b,
                                                input logic [31:0] count,
                                                input logic [63:0] acc,
                                                input logic [63:0] word_a,
                                                input logic [63:0] word_b);
        mac_request_t req;
        req.kind           = KIND_START;
        req.base_a         = base_a;
        req.base_b         = base_b;
        req.step_count     = count;
        req.initial_acc    = acc;
        req.initial_word_a = word_a;
        req.initial_word_b = word_b;
        req.mem_word_a     = rand64();
        req.mem_word_b     = rand64();
        return req;
    endfunction

    function automatic mac_request_t make_tick(input logic [63:0] word_a,
                                               input logic [63:0] word_b);
        mac_request_t req;
        req.kind           = KIND_TICK;
        req.base_a         = rand32();
        req.base_b         = rand32();
        req.step_count     = rand32();
        req.initial_acc    = rand64();
        req.initial_word_a = rand64();
        req.initial_word_b = rand64();
        req.mem_word_a     = word_a;
        req.mem_word_b     = word_b;
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input mac_request_t req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req.kind;
        s_tdata  <= {req.mem_word_b, req.mem_word_a, req.initial_word_b,
                     req.initial_word_a, req.initial_acc, req.step_count,
                     req.base_b, req.base_a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_snapshots.push_back(advance_engine(req));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_snapshots.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == REG_STRIDE_A)
            stride_a_q = value;
        else if (index == REG_STRIDE_B)
            stride_b_q = value;
    endtask

    task automatic test_idle_after_reset();
        send_request(make_tick(rand64(), rand64()));
        write_register(REG_SPARE_LO, '1);
        write_register(REG_SPARE_HI, $urandom);
        send_request(make_tick('1, '1));
    endtask

    task automatic test_directed_runs();
        send_request(make_start('1, '1, '0, '1, '1, '1));
        send_request(make_tick(rand64(), rand64()));
        write_register(REG_STRIDE_A, '1);
        write_register(REG_STRIDE_B, 32'd1);
        send_request(make_start('1, 32'hFFFF_FFFE, 32'd3, '1, '1, '1));
        send_request(make_tick('1, '1));
        send_request(make_tick('0, '1));
        send_request(make_tick(rand64(), rand64()));
        send_request(make_tick(rand64(), rand64()));
        write_register(REG_STRIDE_A, '0);
        write_register(REG_STRIDE_B, '1);
        send_request(make_start($urandom, $urandom, '1, rand64(), rand64(), rand64()));
        send_request(make_tick('1, '1));
        send_request(make_tick(rand64(), rand64()));
        send_request(make_start('0, '0, 32'd2, '0, '1, 64'd2));
        send_request(make_tick(rand64(), rand64()));
        send_request(make_tick(rand64(), rand64()));
        send_request(make_tick(rand64(), rand64()));
        send_request(make_start($urandom, $urandom, 32'd1, rand64(), '0, '0));
        send_request(make_tick('0, '0));
    endtask

    task automatic test_random_runs();
        int sent;
        int quota;
        int steps;
        int idle_ticks;
        int pick;
        logic [31:0] count;
        mac_request_t req;
        quota = RANDOM_ITEMS / RANDOM_PHASES;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_register(REG_STRIDE_A, (phase == 0) ? '1 : rand32());
            write_register(REG_STRIDE_B, (phase == 0) ? '0 : rand32());
            sent = 0;
            while (sent < quota)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 5)
                        count = '0;
                    else if (pick < 9)
                        count = $urandom;
                    else
                        count = $urandom_range(1, 12);
                    send_request(make_start($urandom, $urandom, count,
                                            rand64(), rand64(), rand64()));
                    steps = (count > 16) ? $urandom_range(1, 16) : int'(count);
                    if (steps > 0 && $urandom_range(0, 9) == 0)
                        steps = $urandom_range(0, steps - 1);
                    idle_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                    repeat (steps + idle_ticks)
                        send_request(make_tick(rand64(), rand64()));
                    sent += 1 + steps + idle_ticks;
                end
                else
                begin
                    req = make_tick(rand64(), rand64());
                    if ($urandom_range(0, 1) == 0)
                        req.kind = KIND_START;
                    send_request(req);
                    sent++;
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
            rx_period    = $urandom_range(2, 6);
            rx_phase     = 0;
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_phase % rx_period) == 0;
            default: m_tready <= (rx_phase % 24) >= 16;
        endcase
    end

    always @(posedge clk)
    begin : result_check
        engine_snapshot_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_snapshots.size() == 0)
                report_mismatch("unexpected result", m_tdata[63:0], '0);
            else
            begin
                want = expected_snapshots.pop_front();
                if (m_tdata[OUT_ADDR_A_LSB +: ADDR_FIELD_W] !== want.read_addr_a)
                    report_mismatch("read_addr_a",
                                    64'(m_tdata[OUT_ADDR_A_LSB +: ADDR_FIELD_W]),
                                    64'(want.read_addr_a));
                if (m_tdata[OUT_ADDR_B_LSB +: ADDR_FIELD_W] !== want.read_addr_b)
                    report_mismatch("read_addr_b",
                                    64'(m_tdata[OUT_ADDR_B_LSB +: ADDR_FIELD_W]),
                                    64'(want.read_addr_b));
                if (m_tdata[OUT_ACC_LSB +: DATA_FIELD_W] !== want.accumulator)
                    report_mismatch("accumulator", m_tdata[OUT_ACC_LSB +: DATA_FIELD_W],
                                    want.accumulator);
                if (m_tdata[OUT_STEPS_LSB +: COUNT_FIELD_W] !== want.steps_left)
                    report_mismatch("steps_left",
                                    64'(m_tdata[OUT_STEPS_LSB +: COUNT_FIELD_W]),
                                    64'(want.steps_left));
                if (m_tdata[OUT_BUSY_BIT] !== want.busy)
                    report_mismatch("busy", 64'(m_tdata[OUT_BUSY_BIT]), 64'(want.busy));
                if (m_tdata[OUT_DONE_BIT] !== want.done)
                    report_mismatch("done", 64'(m_tdata[OUT_DONE_BIT]), 64'(want.done));
                if (m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0)
                    report_mismatch("padding", 64'(m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]),
                                    '0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stalled_cycles <= 0;
        else if (stalled_cycles == WATCHDOG_LIMIT)
        begin
            $display("strided_dot_product_engine_top test failed");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        #1 rst_n = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_idle_after_reset();
        test_directed_runs();
        test_random_runs();
        wait_drained();
        if (mismatch_count == 0)
            $display("strided_dot_product_engine_top test passed");
        else
            $display("strided_dot_product_engine_top test failed");
        $finish;
    end

endmodule
